@@ rtl/wpss_pkg.sv @@
`default_nettype none

package wpss_pkg;

  // script bytes and character folding
  localparam int unsigned BYTE_W    = 8;
  localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [BYTE_W-1:0] CASE_BIT     = 8'h20;

  // window and rule set
  localparam int unsigned WINDOW_BYTES = 64;
  localparam int unsigned TABLE_SIZE   = 18;
  localparam int unsigned RULE_COUNT   = 18;
  localparam int unsigned MAX_PAT_LEN  = 58;
  localparam int unsigned CMP_BYTES    =
    (MAX_PAT_LEN < WINDOW_BYTES) ? MAX_PAT_LEN : WINDOW_BYTES;

  // scoring
  localparam int unsigned SCORE_W     = 10;
  localparam int unsigned GROUP_RULES = 6;
  localparam int unsigned GROUP_COUNT = (RULE_COUNT + GROUP_RULES - 1) / GROUP_RULES;

  // configuration
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THREAT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL = 2'd1;
  localparam logic [SCORE_W-1:0] THREAT_RESET   = 10'd60;
  localparam logic [SCORE_W-1:0] CRITICAL_RESET = 10'd90;

  // result word
  localparam int unsigned RES_W       = 1 + 2 + SCORE_W + RULE_COUNT;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  typedef logic [WINDOW_BYTES-1:0][BYTE_W-1:0] win_t;
  typedef logic [MAX_PAT_LEN-1:0][BYTE_W-1:0]  pat_t;

  typedef enum logic [1:0] {
    SEV_NONE     = 2'd0,
    SEV_HIGH     = 2'd1,
    SEV_CRITICAL = 2'd2
  } severity_e;

  typedef struct packed {
    logic                  valid;
    logic [RULE_COUNT-1:0] hits;
  } hits_req_t;

  typedef struct packed {
    logic [SCORE_W-1:0] threat;
    logic [SCORE_W-1:0] critical;
  } thresholds_t;

  // signature text, first character in the highest used byte; byte j of a
  // pattern lines up with the window byte that arrived j bytes ago
  localparam pat_t PAT_TEXT [TABLE_SIZE] = '{
    pat_t'("-encodedcommand"),
    pat_t'("-enc "),
    pat_t'("-nop -w hidden"),
    pat_t'("invoke-expression"),
    pat_t'("iex("),
    pat_t'("[system.convert]::frombase64string"),
    pat_t'("certutil -urlcache"),
    pat_t'("certutil -decode"),
    pat_t'("bitsadmin /transfer"),
    pat_t'("vssadmin delete shadows"),
    pat_t'("wmic shadowcopy delete"),
    pat_t'("bcdedit /set {default} recoveryenabled no"),
    pat_t'({"reg add hklm\\software\\mic", "rosoft\\win", "dows\\currentversion\\run"}),
    pat_t'("downloadstring("),
    pat_t'("downloadfile("),
    pat_t'("wscript.shell"),
    pat_t'("createobject(\"shell.application\")"),
    pat_t'("net.webclient")
  };

  localparam int unsigned PAT_LEN [TABLE_SIZE] = '{
    15, 5, 14, 17, 4, 34, 18, 16, 19, 23, 22, 41, 58, 15, 13, 13, 33, 13
  };

  localparam logic [SCORE_W-1:0] PAT_WEIGHT [TABLE_SIZE] = '{
    10'd40, 10'd35, 10'd35, 10'd25, 10'd25, 10'd35, 10'd45, 10'd45, 10'd40,
    10'd50, 10'd50, 10'd45, 10'd30, 10'd25, 10'd25, 10'd20, 10'd20, 10'd20
  };

endpackage

`default_nettype wire

@@ rtl/wpss_match.sv @@
`default_nettype none

module wpss_match import wpss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              in_last_i,
  output hits_req_t         hits_req_o,
  input  logic              hits_ready_i
);

  logic                  v1_q;
  logic [BYTE_W-1:0]     byte1_q;
  logic                  last1_q;
  win_t                  win_q, win_d, win_shift;
  logic [RULE_COUNT-1:0] hits_q, hits_d, hits_upd, match;
  logic                  stopped_q, stopped_d;
  logic                  fire, halt;
  logic [BYTE_W-1:0]     folded;

  // a final byte waits here until the scorer can take its hit mask
  assign fire       = v1_q && (!last1_q || hits_ready_i);
  assign in_ready_o = !v1_q || fire;

  assign halt   = stopped_q || (byte1_q == CHAR_NUL);
  assign folded = ((byte1_q >= CHAR_UPPER_A) && (byte1_q <= CHAR_UPPER_Z)) ?
                  (byte1_q | CASE_BIT) : byte1_q;
  assign win_shift = {win_q[WINDOW_BYTES-2:0], folded};

  // all signatures against the tail of the shifted window
  always_comb begin
    for (int r = 0; r < RULE_COUNT; r++) begin
      match[r] = (PAT_LEN[r] <= WINDOW_BYTES);
      for (int j = 0; j < CMP_BYTES; j++) begin
        if ((j < PAT_LEN[r]) && (win_shift[j] != PAT_TEXT[r][j])) begin
          match[r] = 1'b0;
        end
      end
    end
  end

  assign hits_upd = halt ? hits_q : (hits_q | match);

  assign hits_req_o.valid = v1_q && last1_q;
  assign hits_req_o.hits  = hits_upd;

  always_comb begin
    if (last1_q) begin
      win_d     = '0;
      hits_d    = '0;
      stopped_d = 1'b0;
    end else begin
      win_d     = halt ? win_q : win_shift;
      hits_d    = hits_upd;
      stopped_d = halt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      win_q     <= '0;
      hits_q    <= '0;
      stopped_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (fire) begin
        win_q     <= win_d;
        hits_q    <= hits_d;
        stopped_q <= stopped_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte1_q <= in_byte_i;
      last1_q <= in_last_i;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last1_q) |=> (hits_q == '0 && !stopped_q && win_q == '0))
    else $error("scan state not cleared after final byte");

  a_stopped_holds_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && stopped_q && !last1_q) |=> ($stable(win_q) && $stable(hits_q)))
    else $error("window or hits moved after a nul byte");

  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && last1_q && !hits_ready_i))
    else $error("input stalled without a pending final byte");
`endif

endmodule

`default_nettype wire

@@ rtl/wpss_score.sv @@
`default_nettype none

module wpss_score import wpss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hits_req_t             hits_req_i,
  output logic                  hits_ready_o,
  input  thresholds_t           thr_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic                  alarm_o,
  output severity_e             severity_o,
  output logic [SCORE_W-1:0]    score_o,
  output logic [RULE_COUNT-1:0] rule_hits_o
);

  logic                  v2_q, v3_q, v4_q;
  logic [RULE_COUNT-1:0] mask2_q, mask3_q, mask4_q;
  logic [SCORE_W-1:0]    part_d [GROUP_COUNT];
  logic [SCORE_W-1:0]    part_q [GROUP_COUNT];
  logic [SCORE_W-1:0]    total, score4_q;
  logic                  threat, threat4_q;
  severity_e             sev, sev4_q;
  logic                  take2, take3, take4, mv2, mv3;

  assign take4 = !v4_q || res_ready_i;
  assign mv3   = v3_q && take4;
  assign take3 = !v3_q || mv3;
  assign mv2   = v2_q && take3;
  assign take2 = !v2_q || mv2;

  assign hits_ready_o = take2;

  // group sums of weights
  always_comb begin
    for (int g = 0; g < GROUP_COUNT; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < GROUP_RULES; k++) begin
        if ((g * GROUP_RULES + k < RULE_COUNT) && mask2_q[g * GROUP_RULES + k]) begin
          part_d[g] = part_d[g] + PAT_WEIGHT[g * GROUP_RULES + k];
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      total = total + part_q[g];
    end
  end

  assign threat = (total >= thr_i.threat);

  always_comb begin
    priority if (!threat) begin
      sev = SEV_NONE;
    end else if (total >= thr_i.critical) begin
      sev = SEV_CRITICAL;
    end else begin
      sev = SEV_HIGH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (take2) begin
        v2_q <= hits_req_i.valid;
      end
      if (take3) begin
        v3_q <= v2_q;
      end
      if (take4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hits_req_i.valid && take2) begin
      mask2_q <= hits_req_i.hits;
    end
    if (mv2) begin
      mask3_q <= mask2_q;
      part_q  <= part_d;
    end
    if (mv3) begin
      mask4_q   <= mask3_q;
      score4_q  <= total;
      threat4_q <= threat;
      sev4_q    <= sev;
    end
  end

  assign res_valid_o = v4_q;
  assign alarm_o     = threat4_q;
  assign severity_o  = sev4_q;
  assign score_o     = score4_q;
  assign rule_hits_o = mask4_q;

`ifndef ASSERT_OFF
  a_no_threat_no_severity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !threat4_q) |-> (sev4_q == SEV_NONE))
    else $error("severity set on a clean script");

  a_threat_meets_threshold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && threat4_q) |-> (score4_q >= thr_i.threat))
    else $error("threat flagged below threshold");

  a_result_from_sum_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v4_q) |-> $past(v3_q))
    else $error("result appeared without a summed mask");
`endif

endmodule

`default_nettype wire

@@ rtl/weighted_pattern_script_scan_core.sv @@
`default_nettype none

// Script signature scanner. Script text streams in one byte per request on the
// slave side, tlast marking the final byte of a script. Each byte is folded to
// lower case and shifted into a 64-byte history window; all 18 signatures are
// compared against the window tail in the same cycle and set sticky hit bits. A
// nul byte freezes matching until the script ends. The final byte yields one
// result request on the master side: the weight sum of the hit rules, the hit
// mask and a threat flag with severity (high at or above threat_threshold,
// critical at or above both thresholds); the window and hits then clear.
// Bytes are taken one per clock, across script boundaries too, unless a final
// byte is held; the rate is set by the combinational window compare. After its
// final byte is registered, a result passes the hit mask, group sum and result
// registers. Input stalls only when a final byte meets a full result path. The
// cfg channel writes thresholds (index 0 threat, 1 critical, others ignored);
// the user must write only while the block is idle, which it does not enforce.
module weighted_pattern_script_scan_core import wpss_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // script byte stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] script_byte
  input  logic                   s_axis_tlast,   // end_of_script
  // scan result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // alarm, severity[1:0],
                                                 // score[9:0], rule_hits[17:0]
  // threshold writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SCORE_W-1:0]     cfg_data_i
);

  hits_req_t             hits_req;
  logic                  hits_ready;
  thresholds_t           thr_q;
  logic                  alarm;
  severity_e             severity;
  logic [SCORE_W-1:0]    score;
  logic [RULE_COUNT-1:0] rule_hits;

  // threshold registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.threat   <= THREAT_RESET;
      thr_q.critical <= CRITICAL_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THREAT:   thr_q.threat   <= cfg_data_i;
        CFG_CRITICAL: thr_q.critical <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // window, compare and sticky hits
  wpss_match u_match (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .hits_req_o   (hits_req),
    .hits_ready_i (hits_ready)
  );

  // weight sum, threshold compare, result register
  wpss_score u_score (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hits_req_i   (hits_req),
    .hits_ready_o (hits_ready),
    .thr_i        (thr_q),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .alarm_o      (alarm),
    .severity_o   (severity),
    .score_o      (score),
    .rule_hits_o  (rule_hits)
  );

  // pack result, lowest field first, zero fill to whole bytes
  assign m_axis_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, rule_hits, score, severity, alarm};

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import wpss_pkg::*;

  localparam int unsigned WIN          = WINDOW_BYTES;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_BYTES  = 8;
  localparam int unsigned PHASE_RUNS   = 1;

  // indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  // one scan verdict, laid out as on m_axis_tdata (alarm flag in bit 0)
  typedef struct packed {
    logic [RULE_COUNT-1:0] hits;
    logic [SCORE_W-1:0]    score;
    severity_e             sev;
    logic                  threat;
  } verdict_t;

  typedef struct {
    string                 text;
    int                    nul_at;   // position of an inserted nul byte, -1 for none
    bit                    typed;    // verdict below is taken as is
    logic [RULE_COUNT-1:0] hits;
    logic [SCORE_W-1:0]    score;
    severity_e             sev;
    logic                  threat;
  } script_row_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata  = '0;   // [7:0] script_byte
  logic                   s_axis_tlast  = 1'b0; // end_of_script
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // alarm, severity[1:0], score[9:0],
                                                // rule_hits[17:0]
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = CFG_THREAT;
  logic [SCORE_W-1:0]     cfg_data_i    = '0;

  weighted_pattern_script_scan_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // signature set with weights, lower case
  string sig_text [RULE_COUNT] = '{
    "-encodedcommand",
    "-enc ",
    "-nop -w hidden",
    "invoke-expression",
    "iex(",
    "[system.convert]::frombase64string",
    "certutil -urlcache",
    "certutil -decode",
    "bitsadmin /transfer",
    "vssadmin delete shadows",
    "wmic shadowcopy delete",
    "bcdedit /set {default} recoveryenabled no",
    {"reg add hklm\\software\\mi", "crosoft\\win", "dows\\currentversion\\run"},
    "downloadstring(",
    "downloadfile(",
    "wscript.shell",
    "createobject(\"shell.application\")",
    "net.webclient"
  };
  int unsigned sig_weight [RULE_COUNT] = '{
    40, 35, 35, 25, 25, 35, 45, 45, 40, 50, 50, 45, 30, 25, 25, 20, 20, 20
  };

  // scanner state as the block should hold it
  logic [7:0]            win_q [WIN];
  logic [RULE_COUNT-1:0] hits_q;
  bit                    stopped_q;
  logic [SCORE_W-1:0]    thr_q;
  logic [SCORE_W-1:0]    crit_q;

  verdict_t    verdict_q [$];   // verdicts still owed by the block
  logic [7:0]  script_q  [$];   // bytes of the script being sent
  script_row_t dir_rows  [$];

  int unsigned errors       = 0;
  int unsigned result_cnt   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned burst_left   = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_bad(input string what);
    errors++;
    $display("mismatch at result %0d: %s", result_cnt, what);
  endtask

  task automatic clear_scan();
    foreach (win_q[i]) win_q[i] = 8'h00;
    hits_q    = '0;
    stopped_q = 1'b0;
  endtask

  // one accepted byte: fold, shift, match; on the last byte owe a verdict
  task automatic scan_byte(input logic [7:0] raw, input bit last);
    logic [7:0]  b;
    int          len;
    bit          hit;
    int unsigned score;
    verdict_t    v;
    b = raw;
    if (raw == 8'h00) stopped_q = 1'b1;
    if (!stopped_q) begin
      if (b >= "A" && b <= "Z") b = b + 8'd32;
      for (int i = 0; i < WIN - 1; i++) win_q[i] = win_q[i+1];
      win_q[WIN-1] = b;
      for (int r = 0; r < RULE_COUNT; r++) begin
        len = sig_text[r].len();
        if (len > 0 && len <= WIN) begin
          hit = 1'b1;
          for (int k = 0; k < len; k++)
            if (win_q[WIN-len+k] != sig_text[r][k]) hit = 1'b0;
          if (hit) hits_q[r] = 1'b1;
        end
      end
    end
    if (last) begin
      score = 0;
      for (int r = 0; r < RULE_COUNT; r++)
        if (hits_q[r]) score += sig_weight[r];
      v.hits   = hits_q;
      v.score  = score[SCORE_W-1:0];
      v.threat = (score >= thr_q);
      if (!v.threat)            v.sev = SEV_NONE;
      else if (score >= crit_q) v.sev = SEV_CRITICAL;
      else                      v.sev = SEV_HIGH;
      verdict_q.push_back(v);
      clear_scan();
    end
  endtask

  // sender: bursts of random length, random gaps, now and then a long burst
  task automatic push_byte(input logic [7:0] b, input bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_byte(b, last);
  endtask

  task automatic send_script();
    foreach (script_q[i]) push_byte(script_q[i], i == script_q.size() - 1);
  endtask

  // wait for every owed verdict, then for the pipe to run dry
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCORE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_THREAT)        thr_q  = val;
    else if (idx == CFG_CRITICAL) crit_q = val;
  endtask

  task automatic set_thresholds(input logic [SCORE_W-1:0] thr, input logic [SCORE_W-1:0] crit);
    write_reg($urandom_range(0, 1) ? CFG_UNUSED_2 : CFG_UNUSED_3, SCORE_W'($urandom));
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_THREAT, thr);
      write_reg(CFG_CRITICAL, crit);
    end else begin
      write_reg(CFG_CRITICAL, crit);
      write_reg(CFG_THREAT, thr);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
    return c;
  endfunction

  // random script: signatures in random case, the commonest chunk, with near misses,
  // filler text, raw noise and the odd nul byte in between
  task automatic make_script();
    int    chunks;
    int    kind;
    int    n;
    string s;
    script_q.delete();
    chunks = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    for (int c = 0; c < chunks; c++) begin
      kind = $urandom_range(0, 19);
      if (kind < 9) begin
        s = sig_text[$urandom_range(0, RULE_COUNT - 1)];
        for (int k = 0; k < s.len(); k++) script_q.push_back(rand_case(s[k]));
      end else if (kind < 12) begin
        // near miss: one byte bent or the tail cut off
        s = sig_text[$urandom_range(0, RULE_COUNT - 1)];
        n = $urandom_range(0, s.len() - 1);
        for (int k = 0; k < s.len(); k++) begin
          if (k == n && $urandom_range(0, 1) == 1) break;
          script_q.push_back(k == n ? (s[k] ^ 8'h01) : rand_case(s[k]));
        end
      end else if (kind < 16) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 8);
        repeat (n)
          script_q.push_back(($urandom_range(0, 5) == 0) ? 8'h20
                             : rand_case(8'("a" + $urandom_range(0, 25))));
      end else if (kind < 19) begin
        repeat ($urandom_range(1, 4)) script_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        script_q.push_back(8'h00);
      end
    end
    if (script_q.size() == 0) script_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // cycle count and timeout
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check each verdict request, stall on one of four patterns
  // picked by bits 9:8 of the cycle count
  always @(posedge clk_i) begin : result_side
    verdict_t got;
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = verdict_t'(m_axis_tdata[RES_W-1:0]);
      if (verdict_q.size() == 0) begin
        report_bad("result with no script pending");
      end else begin
        want = verdict_q.pop_front();
        if (got.threat !== want.threat)
          report_bad($sformatf("alarm %0d, want %0d", got.threat, want.threat));
        if (got.sev !== want.sev)
          report_bad($sformatf("severity %0d, want %0d", got.sev, want.sev));
        if (got.score !== want.score)
          report_bad($sformatf("score %0d, want %0d", got.score, want.score));
        if (got.hits !== want.hits)
          report_bad($sformatf("rule_hits %05h, want %05h", got.hits, want.hits));
      end
      result_cnt++;
    end
    case (cycle_cnt[9:8])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_axis_tready <= cycle_cnt[3];
      default: m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  initial begin
    string              all_text;
    string              pad;
    logic [SCORE_W-1:0] phase_thr  [PHASES];
    logic [SCORE_W-1:0] phase_crit [PHASES];
    int unsigned        sent;
    int unsigned        runs;
    int                 len;

    clear_scan();
    thr_q  = THREAT_RESET;
    crit_q = CRITICAL_RESET;
    all_text = "";
    foreach (sig_text[r]) all_text = {all_text, sig_text[r], " "};
    pad = {52{"q"}};

    // directed scripts at the reset thresholds (60 / 90)
    dir_rows = '{
      '{"a",                      -1, 1, 18'h00000,  10'd0, SEV_NONE,     1'b0},
      '{"",                        0, 1, 18'h00000,  10'd0, SEV_NONE,     1'b0},
      '{"-encodedcommand",        -1, 1, 18'h00001, 10'd40, SEV_NONE,     1'b0},
      '{"-enc -nop -w hidden",    -1, 0, '0, '0, SEV_NONE, 1'b0},
      // exactly at the threat threshold
      '{"iex(-enc ",              -1, 1, 18'h00012, 10'd60, SEV_HIGH,     1'b1},
      // just below it
      '{"wscript.shell -enc ",    -1, 1, 18'h08002, 10'd55, SEV_NONE,     1'b0},
      // exactly at the critical threshold
      '{"certutil -urlcache certutil -decode",
                                  -1, 1, 18'h000c0, 10'd90, SEV_CRITICAL, 1'b1},
      '{"VSSADMIN DELETE SHADOWS", -1, 0, '0, '0, SEV_NONE, 1'b0},
      // nul in the middle, first and last
      '{"iex(net.webclient",       4, 1, 18'h00010, 10'd25, SEV_NONE,     1'b0},
      '{"-encodedcommand",         0, 1, 18'h00000,  10'd0, SEV_NONE,     1'b0},
      '{"wscript.shell",          13, 1, 18'h08000, 10'd20, SEV_NONE,     1'b0},
      // a signature split over two scripts must not match
      '{"-en",                    -1, 1, 18'h00000,  10'd0, SEV_NONE,     1'b0},
      '{"c x",                    -1, 1, 18'h00000,  10'd0, SEV_NONE,     1'b0},
      '{all_text,                 -1, 1, 18'h3ffff, 10'd610, SEV_CRITICAL, 1'b1},
      // longest signature after the window has rolled over
      '{{"0123456789", sig_text[12].toupper()}, -1, 0, '0, '0, SEV_NONE, 1'b0},
      '{{pad, "Net.WebClient"},   -1, 0, '0, '0, SEV_NONE, 1'b0},
      '{{"net.webclient", pad},   -1, 0, '0, '0, SEV_NONE, 1'b0},
      // folding edges: only A..Z change
      '{"@[`{AZaz",               -1, 0, '0, '0, SEV_NONE, 1'b0},
      '{"downloadstring downloadfile(", -1, 0, '0, '0, SEV_NONE, 1'b0},
      '{"DownloadString(",        -1, 0, '0, '0, SEV_NONE, 1'b0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[n]) begin
      script_q.delete();
      len = dir_rows[n].text.len();
      for (int k = 0; k <= len; k++) begin
        if (k == dir_rows[n].nul_at) script_q.push_back(8'h00);
        if (k < len) script_q.push_back(dir_rows[n].text[k]);
      end
      send_script();
      if (dir_rows[n].typed)
        verdict_q[verdict_q.size() - 1] = '{dir_rows[n].hits, dir_rows[n].score,
                                             dir_rows[n].sev, dir_rows[n].threat};
    end

    // random scripts under several threshold settings, extremes first
    phase_thr  = '{10'd0, 10'd1023, 10'd100, 10'd0,    10'd0, 10'd60};
    phase_crit = '{10'd0, 10'd1023, 10'd50,  10'd1023, 10'd0, 10'd90};
    phase_thr[4]  = SCORE_W'($urandom_range(20, 200));
    phase_crit[4] = SCORE_W'($urandom_range(20, 200));

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_thresholds(phase_thr[p], phase_crit[p]);
      sent = 0;
      runs = 0;
      while (sent < PHASE_BYTES || runs < PHASE_RUNS) begin
        make_script();
        sent += script_q.size();
        runs++;
        send_script();
      end
    end
    settle();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/wpss_pkg.sv
rtl/wpss_match.sv
rtl/wpss_score.sv
rtl/weighted_pattern_script_scan_core.sv
sim/tb_top.sv
